[rtl/bdq_pkg.sv]
// Package for the bounded deque with search.
// Holds the request mode codes, result status codes and default sizes.
// Has no dependencies.
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic [1:0] MODE_PUSH     = 2'd0;
    localparam logic [1:0] MODE_POP      = 2'd1;
    localparam logic [1:0] MODE_FIND_FWD = 2'd2;
    localparam logic [1:0] MODE_FIND_BWD = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    localparam logic signed [31:0] EMPTY_DATA = 32'sh8000_0000;

    typedef logic [1:0] code_t;

endpackage

[rtl/bounded_deque_with_search.sv]
// Bounded double-ended store of signed 32-bit values with linear search.
// Depends on bdq_pkg for mode codes, status codes and default depth.
//
// Channel    Direction  Handshake              Fields
// request    in         req_valid / req_ready  mode, value
// result     out        res_valid / res_ready  status, data, position, count
//
// One request is taken at a time: req_ready is high only while the sequencer is idle.
// Push writes in execute, pop reads in a wait state, and a search scans count entries at most,
// since the single memory read port delivers one stored entry per cycle to the shared comparator.
// A finished result waits in the output register while the next request is accepted;
// the sequencer holds the following result until that register has been taken.
// Reset clears state, front index, count and flags; storage and scan registers are not cleared.
module bounded_deque_with_search #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          mode,
    input  logic signed [31:0]  value,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [1:0]          status,
    output logic signed [31:0]  data,
    output logic [3:0]          position,
    output logic [4:0]          count
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW:0]   DEPTH_SUM = (IW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POPW = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic signed [31:0] mem [DEPTH];

    logic [2:0]          state_reg, state_next;
    logic [IW-1:0]       front_reg, front_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    bdq_pkg::code_t      mode_reg;
    logic signed [31:0]  key_reg;
    logic [CW-1:0]       step_reg, step_next;
    logic                pend_reg, pend_next;
    logic [IW-1:0]       pidx_reg, pidx_next;
    bdq_pkg::code_t      wst_reg, wst_next;
    logic signed [31:0]  wdat_reg, wdat_next;
    logic [IW-1:0]       wpos_reg, wpos_next;
    logic signed [31:0]  rdata_reg;

    logic                res_valid_reg;
    bdq_pkg::code_t      status_reg;
    logic signed [31:0]  data_reg;
    logic [3:0]          position_reg;
    logic [4:0]          count_reg;

    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [IW-1:0]       log_idx;
    logic [IW-1:0]       last_idx;
    logic                load_out;
    logic [IW+3:0]       pos_wide;
    logic [CW+4:0]       cnt_wide;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] front,
                                              input logic [IW-1:0] idx);
        logic [IW:0] sum;
        sum = {1'b0, front} + {1'b0, idx};
        if (sum >= DEPTH_SUM)
        begin
            sum = sum - DEPTH_SUM;
        end
        return sum[IW-1:0];
    endfunction

    assign req_ready = (state_reg == S_IDLE);
    assign last_idx  = IW'(cnt_reg - CW'(1));
    assign log_idx   = (mode_reg == bdq_pkg::MODE_FIND_FWD) ? step_reg[IW-1:0]
                                                            : IW'(last_idx - step_reg[IW-1:0]);
    assign load_out  = (state_reg == S_FIN) && (!res_valid_reg || res_ready);
    assign pos_wide  = {4'b0, wpos_reg};
    assign cnt_wide  = {5'b0, cnt_reg};

    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        wst_next   = wst_reg;
        wdat_next  = wdat_reg;
        wpos_next  = wpos_reg;
        rd_addr    = slot_of(front_reg, last_idx);
        wr_en      = 1'b0;
        wr_addr    = (front_reg == '0) ? LAST_SLOT : IW'(front_reg - IW'(1));
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                wdat_next  = '0;
                wpos_next  = '0;
                step_next  = '0;
                state_next = S_FIN;
                unique case (mode_reg)
                    bdq_pkg::MODE_PUSH:
                    begin
                        if (cnt_reg == DEPTH_CNT)
                        begin
                            wst_next = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            wst_next   = bdq_pkg::ST_OK;
                            wr_en      = 1'b1;
                            front_next = wr_addr;
                            cnt_next   = cnt_reg + CW'(1);
                        end
                    end
                    bdq_pkg::MODE_POP:
                    begin
                        if (cnt_reg == '0)
                        begin
                            wst_next  = bdq_pkg::ST_EMPTY;
                            wdat_next = bdq_pkg::EMPTY_DATA;
                        end
                        else
                        begin
                            wst_next   = bdq_pkg::ST_OK;
                            state_next = S_POPW;
                        end
                    end
                    default:
                    begin
                        wst_next = bdq_pkg::ST_MISS;
                        if (cnt_reg != '0)
                        begin
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end
            S_POPW:
            begin
                wdat_next  = rdata_reg;
                cnt_next   = cnt_reg - CW'(1);
                state_next = S_FIN;
            end
            S_SCAN:
            begin
                rd_addr = slot_of(front_reg, log_idx);
                if (pend_reg && (rdata_reg == key_reg))
                begin
                    wst_next   = bdq_pkg::ST_OK;
                    wpos_next  = pidx_reg;
                    state_next = S_FIN;
                end
                else if (step_reg == cnt_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    pend_next = 1'b1;
                    pidx_next = log_idx;
                    step_next = step_reg + CW'(1);
                end
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= key_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            mode_reg <= mode;
            key_reg  <= value;
        end
        step_reg <= step_next;
        pidx_reg <= pidx_next;
        wst_reg  <= wst_next;
        wdat_reg <= wdat_next;
        wpos_reg <= wpos_next;
        if (load_out)
        begin
            status_reg   <= wst_reg;
            data_reg     <= wdat_reg;
            position_reg <= pos_wide[3:0];
            count_reg    <= cnt_wide[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign position  = position_reg;
    assign count     = count_reg;

endmodule
